@@ hdl/ray_box_slab_test_top_assert.svh @@
// Assertion macros used by the slab test top level.
`ifndef RAY_BOX_SLAB_TEST_TOP_ASSERT_SVH
`define RAY_BOX_SLAB_TEST_TOP_ASSERT_SVH

// Clocked assertion, disabled while reset is applied.
`define RBST_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("ray box slab test assertion failed");

// Clocked check that a condition never holds outside reset.
`define RBST_ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("ray box slab test forbidden condition seen");

`endif

@@ hdl/rbst_pkg.sv @@
// Shared types and constants for the ray versus box slab test.
package rbst_pkg;

    localparam int WORD_W  = 32;
    localparam int FRAC_W  = 16;
    localparam int NUM_W   = WORD_W + 1;
    localparam int DVD_W   = NUM_W + FRAC_W;
    localparam int CMP_W   = 2 * WORD_W + 1;
    localparam int DIV_LAT = WORD_W + 2;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic signed [NUM_W-1:0]  num_t;

    localparam word_t T_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam word_t T_MIN = {1'b1, {(WORD_W-1){1'b0}}};

endpackage

@@ hdl/rbst_div.sv @@
// Pipelined fixed-point divider, one quotient bit per stage, saturating.
module rbst_div
(
    input  logic          clk,
    input  logic          en,
    input  rbst_pkg::num_t  num,
    input  rbst_pkg::word_t den,
    output rbst_pkg::word_t quo
);

    logic [rbst_pkg::NUM_W-1:0]  n_mag;
    logic [rbst_pkg::WORD_W-1:0] d_mag;
    logic                        ovf0;

    logic [rbst_pkg::DVD_W-1:0]  rem_reg [0:rbst_pkg::WORD_W];
    logic [rbst_pkg::WORD_W-1:0] q_reg   [0:rbst_pkg::WORD_W];
    logic [rbst_pkg::WORD_W-1:0] d_reg   [0:rbst_pkg::WORD_W];
    logic                        neg_reg [0:rbst_pkg::WORD_W];
    logic                        ovf_reg [0:rbst_pkg::WORD_W];

    logic [rbst_pkg::WORD_W-1:0] limit;
    logic [rbst_pkg::WORD_W-1:0] q_sat;
    rbst_pkg::word_t             quo_next;
    rbst_pkg::word_t             quo_reg;

    // Magnitudes and the early check for a quotient of 2^WORD_W or more.
    always_comb
    begin
        n_mag = num[rbst_pkg::NUM_W-1] ? rbst_pkg::NUM_W'(-num) : rbst_pkg::NUM_W'(num);
        d_mag = den[rbst_pkg::WORD_W-1] ? rbst_pkg::WORD_W'(-den) : rbst_pkg::WORD_W'(den);
        ovf0  = ({{(rbst_pkg::CMP_W-rbst_pkg::DVD_W){1'b0}}, n_mag, {rbst_pkg::FRAC_W{1'b0}}})
                >= ({1'b0, d_mag, {rbst_pkg::WORD_W{1'b0}}});
    end

    // Entry stage of the divider.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= {n_mag, {rbst_pkg::FRAC_W{1'b0}}};
            q_reg[0]   <= '0;
            d_reg[0]   <= d_mag;
            neg_reg[0] <= num[rbst_pkg::NUM_W-1] ^ den[rbst_pkg::WORD_W-1];
            ovf_reg[0] <= ovf0;
        end
    end

    // One restoring step per stage, most significant quotient bit first.
    for (genvar k = 0; k < rbst_pkg::WORD_W; k++)
    begin : g_stage
        localparam int B = rbst_pkg::WORD_W - 1 - k;
        logic [rbst_pkg::CMP_W-1:0] trial;
        logic [rbst_pkg::CMP_W-1:0] rem_ext;
        logic                       ge;

        always_comb
        begin
            trial   = rbst_pkg::CMP_W'(d_reg[k]) << B;
            rem_ext = rbst_pkg::CMP_W'(rem_reg[k]);
            ge      = rem_ext >= trial;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1] <= ge ? rbst_pkg::DVD_W'(rem_ext - trial) : rem_reg[k];
                q_reg[k+1]   <= q_reg[k] | (rbst_pkg::WORD_W'(ge) << B);
                d_reg[k+1]   <= d_reg[k];
                neg_reg[k+1] <= neg_reg[k];
                ovf_reg[k+1] <= ovf_reg[k];
            end
        end
    end

    // Clamp to the signed range and restore the sign.
    always_comb
    begin
        limit    = neg_reg[rbst_pkg::WORD_W] ? rbst_pkg::WORD_W'(rbst_pkg::T_MIN)
                                             : rbst_pkg::WORD_W'(rbst_pkg::T_MAX);
        q_sat    = (ovf_reg[rbst_pkg::WORD_W] || (q_reg[rbst_pkg::WORD_W] > limit))
                   ? limit : q_reg[rbst_pkg::WORD_W];
        quo_next = neg_reg[rbst_pkg::WORD_W] ? rbst_pkg::word_t'(-q_sat)
                                             : rbst_pkg::word_t'(q_sat);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quo_reg <= quo_next;
        end
    end

    assign quo = quo_reg;

endmodule

@@ hdl/rbst_axis.sv @@
// One axis lane: slab entry and exit from two dividers plus zero-direction handling.
module rbst_axis
(
    input  logic            clk,
    input  logic            en,
    input  rbst_pkg::word_t origin,
    input  rbst_pkg::word_t direction,
    input  rbst_pkg::word_t box_low,
    input  rbst_pkg::word_t box_high,
    output rbst_pkg::word_t t_in,
    output rbst_pkg::word_t t_out
);

    rbst_pkg::num_t  diff_lo;
    rbst_pkg::num_t  diff_hi;
    rbst_pkg::word_t q_lo;
    rbst_pkg::word_t q_hi;

    logic zero_reg   [0:rbst_pkg::DIV_LAT-1];
    logic inside_reg [0:rbst_pkg::DIV_LAT-1];
    logic neg_reg    [0:rbst_pkg::DIV_LAT-1];

    // Exact differences, one bit wider than the operands.
    assign diff_lo = rbst_pkg::num_t'(box_low) - rbst_pkg::num_t'(origin);
    assign diff_hi = rbst_pkg::num_t'(box_high) - rbst_pkg::num_t'(origin);

    rbst_div u_div_lo (.clk(clk), .en(en), .num(diff_lo), .den(direction), .quo(q_lo));
    rbst_div u_div_hi (.clk(clk), .en(en), .num(diff_hi), .den(direction), .quo(q_hi));

    // Side flags travel alongside the divider pipeline.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero_reg[0]   <= direction == '0;
            inside_reg[0] <= (box_low <= origin) && (origin <= box_high);
            neg_reg[0]    <= direction[rbst_pkg::WORD_W-1];
            for (int i = 1; i < rbst_pkg::DIV_LAT; i++)
            begin
                zero_reg[i]   <= zero_reg[i-1];
                inside_reg[i] <= inside_reg[i-1];
                neg_reg[i]    <= neg_reg[i-1];
            end
        end
    end

    // Pick the slab bounds: unbounded or empty on a zero direction, swapped when negative.
    always_comb
    begin
        if (zero_reg[rbst_pkg::DIV_LAT-1])
        begin
            t_in  = inside_reg[rbst_pkg::DIV_LAT-1] ? rbst_pkg::T_MIN : rbst_pkg::T_MAX;
            t_out = inside_reg[rbst_pkg::DIV_LAT-1] ? rbst_pkg::T_MAX : rbst_pkg::T_MIN;
        end
        else if (neg_reg[rbst_pkg::DIV_LAT-1])
        begin
            t_in  = q_hi;
            t_out = q_lo;
        end
        else
        begin
            t_in  = q_lo;
            t_out = q_hi;
        end
    end

endmodule

@@ hdl/rbst_merge.sv @@
// Merges the three axis slabs into the hit flag and the output register.
module rbst_merge
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            valid_in,
    input  rbst_pkg::word_t t_in_x,
    input  rbst_pkg::word_t t_in_y,
    input  rbst_pkg::word_t t_in_z,
    input  rbst_pkg::word_t t_out_x,
    input  rbst_pkg::word_t t_out_y,
    input  rbst_pkg::word_t t_out_z,
    output logic            out_valid,
    output logic            hit,
    output rbst_pkg::word_t t_enter,
    output rbst_pkg::word_t t_leave
);

    rbst_pkg::word_t enter_xy;
    rbst_pkg::word_t leave_xy;
    rbst_pkg::word_t enter_next;
    rbst_pkg::word_t leave_next;
    rbst_pkg::word_t enter_reg;
    rbst_pkg::word_t leave_reg;
    logic            hit_reg;
    logic            valid_reg;

    // Largest entry and smallest exit over the axes.
    always_comb
    begin
        enter_xy   = (t_in_y > t_in_x) ? t_in_y : t_in_x;
        enter_next = (t_in_z > enter_xy) ? t_in_z : enter_xy;
        leave_xy   = (t_out_y < t_out_x) ? t_out_y : t_out_x;
        leave_next = (t_out_z < leave_xy) ? t_out_z : leave_xy;
    end

    // Output register, held while the receiver stalls.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            enter_reg <= enter_next;
            leave_reg <= leave_next;
            hit_reg   <= enter_next <= leave_next;
        end
    end

    assign out_valid = valid_reg;
    assign hit       = hit_reg;
    assign t_enter   = enter_reg;
    assign t_leave   = leave_reg;

endmodule

@@ hdl/ray_box_slab_test_top.sv @@
// Top level of the ray versus axis-aligned box slab test.
//
// Usage: one request on the input channel carries a ray (origin, direction)
// and a box (low and high corners), all signed Q16.16. One result leaves on
// the output channel for every request: hit, t_enter and t_leave.
// Both channels use valid and ready.
// From acceptance to out_valid a request passes one entry stage and
// 32 quotient-bit stages in each divider, one saturation stage, and the
// output register after the axis merge.
// Throughput is one request per cycle while the receiver does not stall;
// six dividers (two per axis lane) are fully pipelined, and results leave in order.
// When the receiver stalls, the whole pipeline holds and in_ready drops;
// a request is still taken while a result waits if the pipeline can move.
// Reset clears the valid flags of every stage; no result is pending after it.
module ray_box_slab_test_top
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  rbst_pkg::word_t origin_x,
    input  rbst_pkg::word_t origin_y,
    input  rbst_pkg::word_t origin_z,
    input  rbst_pkg::word_t direction_x,
    input  rbst_pkg::word_t direction_y,
    input  rbst_pkg::word_t direction_z,
    input  rbst_pkg::word_t box_low_x,
    input  rbst_pkg::word_t box_low_y,
    input  rbst_pkg::word_t box_low_z,
    input  rbst_pkg::word_t box_high_x,
    input  rbst_pkg::word_t box_high_y,
    input  rbst_pkg::word_t box_high_z,
    output logic            out_valid,
    input  logic            out_ready,
    output logic            hit,
    output rbst_pkg::word_t t_enter,
    output rbst_pkg::word_t t_leave
);

`include "ray_box_slab_test_top_assert.svh"

    logic            advance;
    logic            vld_reg [0:rbst_pkg::DIV_LAT-1];
    rbst_pkg::word_t tin_x, tin_y, tin_z;
    rbst_pkg::word_t tout_x, tout_y, tout_z;

    // The pipeline moves unless a finished result is held by the receiver.
    assign advance  = !out_valid || out_ready;
    assign in_ready = advance;

    // Valid flags alongside the divider stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < rbst_pkg::DIV_LAT; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (advance)
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < rbst_pkg::DIV_LAT; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    rbst_axis u_axis_x
    (
        .clk(clk), .en(advance), .origin(origin_x), .direction(direction_x),
        .box_low(box_low_x), .box_high(box_high_x), .t_in(tin_x), .t_out(tout_x)
    );

    rbst_axis u_axis_y
    (
        .clk(clk), .en(advance), .origin(origin_y), .direction(direction_y),
        .box_low(box_low_y), .box_high(box_high_y), .t_in(tin_y), .t_out(tout_y)
    );

    rbst_axis u_axis_z
    (
        .clk(clk), .en(advance), .origin(origin_z), .direction(direction_z),
        .box_low(box_low_z), .box_high(box_high_z), .t_in(tin_z), .t_out(tout_z)
    );

    rbst_merge u_merge
    (
        .clk(clk), .rst_n(rst_n), .en(advance), .valid_in(vld_reg[rbst_pkg::DIV_LAT-1]),
        .t_in_x(tin_x), .t_in_y(tin_y), .t_in_z(tin_z),
        .t_out_x(tout_x), .t_out_y(tout_y), .t_out_z(tout_z),
        .out_valid(out_valid), .hit(hit), .t_enter(t_enter), .t_leave(t_leave)
    );

    // The hit flag always agrees with the reported interval.
    `RBST_ASSERT(a_hit_order, clk, rst_n, out_valid |-> (hit == (t_enter <= t_leave)))
    // A finished stage reaches the output when the pipeline moves.
    `RBST_ASSERT(a_last_to_out, clk, rst_n,
        (advance && vld_reg[rbst_pkg::DIV_LAT-1]) |=> out_valid)
    // Input is refused only while a result is held by the receiver.
    `RBST_ASSERT(a_ready_rule, clk, rst_n, !in_ready |-> (out_valid && !out_ready))
    // The output valid flag is always a known value once out of reset.
    `RBST_ASSERT_NEVER(a_valid_known, clk, rst_n, $isunknown(out_valid))

endmodule

@@ bench/ray_box_slab_test_top_tb.sv @@
// Self-checking testbench for the ray versus axis-aligned box slab test.
`timescale 1ns / 1ps

module ray_box_slab_test_top_tb;

    localparam int RESET_CYCLES = 9;
    localparam int RANDOM_RAYS  = 1000;
    localparam int DRAIN_CYCLES = rbst_pkg::DIV_LAT + 20;
    localparam int STALL_LIMIT  = 5000;
    localparam logic signed [63:0] WIDE_MAX = 64'sd2147483647;
    localparam logic signed [63:0] WIDE_MIN = -64'sd2147483648;

    // One ray and box pair as it travels on the input channel.
    typedef struct packed {
        rbst_pkg::word_t ox, oy, oz;
        rbst_pkg::word_t dx, dy, dz;
        rbst_pkg::word_t lx, ly, lz;
        rbst_pkg::word_t hx, hy, hz;
    } ray_box_t;

    // One slab test outcome.
    typedef struct packed {
        logic            hit;
        rbst_pkg::word_t enter;
        rbst_pkg::word_t leave;
    } slab_hit_t;

    // A directed row; the outcome is typed in only where known is set.
    typedef struct {
        ray_box_t  rb;
        logic      known;
        slab_hit_t outcome;
    } directed_row_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic out_valid;
    logic out_ready;
    ray_box_t req;
    logic            hit;
    rbst_pkg::word_t t_enter;
    rbst_pkg::word_t t_leave;

    slab_hit_t     pending_hits[$];
    directed_row_t directed_rows[$];
    int errors = 0;
    int rays_sent;
    int hits_seen = 0;
    int results_seen = 0;
    int idle_cycles = 0;
    int send_gap_pct;
    int stall_pct;

    ray_box_slab_test_top dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .origin_x    (req.ox),
        .origin_y    (req.oy),
        .origin_z    (req.oz),
        .direction_x (req.dx),
        .direction_y (req.dy),
        .direction_z (req.dz),
        .box_low_x   (req.lx),
        .box_low_y   (req.ly),
        .box_low_z   (req.lz),
        .box_high_x  (req.hx),
        .box_high_y  (req.hy),
        .box_high_z  (req.hz),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .hit         (hit),
        .t_enter     (t_enter),
        .t_leave     (t_leave)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // Fixed-point quotient truncated toward zero and saturated to a word.
    function automatic logic signed [63:0] slab_quotient(logic signed [63:0] num,
                                                       logic signed [63:0] den);
        logic [63:0] n;
        logic [63:0] d;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] limit;
        logic        neg;
        n = num < 0 ? -num : num;
        d = den < 0 ? -den : den;
        neg = (num < 0) != (den < 0);
        limit = neg ? 64'h8000_0000 : 64'h7fff_ffff;
        q = n / d;
        r = n % d;
        if (q > (limit >> rbst_pkg::FRAC_W))
        begin
            return neg ? WIDE_MIN : WIDE_MAX;
        end
        for (int i = 0; i < rbst_pkg::FRAC_W; i++)
        begin
            r = r << 1;
            q = q << 1;
            if (r >= d)
            begin
                r = r - d;
                q[0] = 1'b1;
            end
        end
        if (q > limit)
        begin
            q = limit;
        end
        return neg ? -$signed(q) : $signed(q);
    endfunction

    // Intersects the ray with the three slabs and merges the intervals.
    function automatic slab_hit_t predict_slab_hit(ray_box_t rb);
        rbst_pkg::word_t o[3];
        rbst_pkg::word_t d[3];
        rbst_pkg::word_t lo[3];
        rbst_pkg::word_t hi[3];
        logic signed [63:0] enter;
        logic signed [63:0] leave;
        logic signed [63:0] e;
        logic signed [63:0] x;
        logic signed [63:0] t0;
        logic signed [63:0] t1;
        slab_hit_t res;
        o = '{rb.ox, rb.oy, rb.oz};
        d = '{rb.dx, rb.dy, rb.dz};
        lo = '{rb.lx, rb.ly, rb.lz};
        hi = '{rb.hx, rb.hy, rb.hz};
        enter = WIDE_MIN;
        leave = WIDE_MAX;
        for (int a = 0; a < 3; a++)
        begin
            if (d[a] == 0)
            begin
                if (lo[a] <= o[a] && o[a] <= hi[a])
                begin
                    e = WIDE_MIN;
                    x = WIDE_MAX;
                end
                else
                begin
                    e = WIDE_MAX;
                    x = WIDE_MIN;
                end
            end
            else
            begin
                t0 = slab_quotient(64'(lo[a]) - 64'(o[a]), 64'(d[a]));
                t1 = slab_quotient(64'(hi[a]) - 64'(o[a]), 64'(d[a]));
                e = d[a] < 0 ? t1 : t0;
                x = d[a] < 0 ? t0 : t1;
            end
            if (e > enter)
            begin
                enter = e;
            end
            if (x < leave)
            begin
                leave = x;
            end
        end
        res.hit = enter <= leave;
        res.enter = enter[rbst_pkg::WORD_W-1:0];
        res.leave = leave[rbst_pkg::WORD_W-1:0];
        return res;
    endfunction

    function automatic rbst_pkg::word_t any_word();
        rbst_pkg::word_t w;
        w = $urandom;
        case ($urandom_range(0, 5))
            0: w = rbst_pkg::T_MAX;
            1: w = rbst_pkg::T_MIN;
            2: w = rbst_pkg::word_t'($signed($urandom_range(0, 20)) - 10) <<< rbst_pkg::FRAC_W;
            default: ;
        endcase
        return w;
    endfunction

    // Mostly small rays aimed near modest boxes so that hits are common.
    function automatic ray_box_t random_ray_box();
        ray_box_t rb;
        rbst_pkg::word_t c;
        rbst_pkg::word_t s;
        rbst_pkg::word_t f[12];
        if ($urandom_range(0, 4) == 0)
        begin
            foreach (f[i])
            begin
                f[i] = any_word();
            end
        end
        else
        begin
            for (int a = 0; a < 3; a++)
            begin
                f[a] = rbst_pkg::word_t'($signed($urandom_range(0, 32'h00ff_ffff))
                                         - 32'sh0080_0000);
                f[3 + a] = ($urandom_range(0, 9) == 0) ? rbst_pkg::word_t'(0)
                    : rbst_pkg::word_t'($signed($urandom_range(0, 32'h0003_ffff))
                                        - 32'sh0002_0000);
                c = rbst_pkg::word_t'($signed($urandom_range(0, 32'h00ff_ffff))
                                      - 32'sh0080_0000);
                s = rbst_pkg::word_t'($urandom_range(0, 32'h0020_0000));
                f[6 + a] = c - s;
                f[9 + a] = ($urandom_range(0, 19) == 0) ? c - s - 1 : c + s;
            end
        end
        rb = {f[0], f[1], f[2], f[3], f[4], f[5], f[6], f[7], f[8], f[9], f[10], f[11]};
        return rb;
    endfunction

    // Presents one request and holds it until accepted.
    task automatic send_ray_box(ray_box_t rb);
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        req <= rb;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        rays_sent++;
    endtask

    function automatic directed_row_t row(ray_box_t rb, logic known, slab_hit_t outcome);
        directed_row_t r;
        r.rb = rb;
        r.known = known;
        r.outcome = outcome;
        return r;
    endfunction

    function automatic ray_box_t cube(rbst_pkg::word_t ox, rbst_pkg::word_t oy,
                                      rbst_pkg::word_t oz, rbst_pkg::word_t dx,
                                      rbst_pkg::word_t dy, rbst_pkg::word_t dz,
                                      rbst_pkg::word_t lo, rbst_pkg::word_t hi);
        return {ox, oy, oz, dx, dy, dz, lo, lo, lo, hi, hi, hi};
    endfunction

    // Directed rows: unit rays, zero directions, saturation and a reversed box.
    task automatic build_directed_rows();
        rbst_pkg::word_t one;
        one = rbst_pkg::word_t'(1) <<< rbst_pkg::FRAC_W;
        // Zero direction, origin inside every slab: unbounded interval.
        directed_rows.push_back(row(cube(0, 0, 0, 0, 0, 0, -one, one), 1'b1,
                                    '{1'b1, rbst_pkg::T_MIN, rbst_pkg::T_MAX}));
        // Zero direction, origin outside: empty interval.
        directed_rows.push_back(row(cube(3 * one, 0, 0, 0, 0, 0, -one, one), 1'b1,
                                    '{1'b0, rbst_pkg::T_MAX, rbst_pkg::T_MIN}));
        // Ray along +x through a unit cube, from x = -2.
        directed_rows.push_back(row(cube(-2 * one, 0, 0, one, 0, 0, -one, one), 1'b1,
                                    '{1'b1, one, 3 * one}));
        // Mirrored ray from x = 2 heading along -x: swap of the pair.
        directed_rows.push_back(row(cube(2 * one, 0, 0, -one, 0, 0, -one, one), 1'b1,
                                    '{1'b1, one, 3 * one}));
        // Extremes of every field and saturating quotients.
        directed_rows.push_back(row(cube(rbst_pkg::T_MIN, rbst_pkg::T_MIN, rbst_pkg::T_MIN,
                                         1, 1, 1, rbst_pkg::T_MAX, rbst_pkg::T_MAX),
                                    1'b0, '0));
        directed_rows.push_back(row(cube(rbst_pkg::T_MAX, rbst_pkg::T_MAX, rbst_pkg::T_MAX,
                                         -1, -1, -1, rbst_pkg::T_MIN, rbst_pkg::T_MIN),
                                    1'b0, '0));
        directed_rows.push_back(row(cube(rbst_pkg::T_MAX, rbst_pkg::T_MIN, 0,
                                         rbst_pkg::T_MIN, rbst_pkg::T_MAX, -1,
                                         rbst_pkg::T_MIN, rbst_pkg::T_MAX),
                                    1'b0, '0));
        directed_rows.push_back(row(cube(-1, -1, -1, rbst_pkg::T_MIN, rbst_pkg::T_MIN,
                                         rbst_pkg::T_MIN, rbst_pkg::T_MIN, rbst_pkg::T_MAX),
                                    1'b0, '0));
        directed_rows.push_back(row(cube(0, 0, 0, 3, -7, 11, -5, 5), 1'b0, '0));
        // Low corner above high corner.
        directed_rows.push_back(row(cube(0, 0, 0, one, one, one, one, -one), 1'b0, '0));
        directed_rows.push_back(row(cube(0, 0, 0, 0, 0, 0, one, -one), 1'b1,
                                    '{1'b0, rbst_pkg::T_MAX, rbst_pkg::T_MIN}));
        // Touching slab: entry equals exit.
        directed_rows.push_back(row(cube(0, 0, 0, one, one, one, one, one), 1'b0, '0));
        directed_rows.push_back(row({rbst_pkg::T_MAX, rbst_pkg::T_MIN, 32'h5555_5555,
                                     32'haaaa_aaaa, 32'h0000_0001, 32'hffff_ffff,
                                     rbst_pkg::T_MIN, 32'h8000_0001, 32'haaaa_aaaa,
                                     rbst_pkg::T_MAX, 32'h7fff_fffe, 32'h5555_5555},
                                    1'b0, '0));
    endtask

    // Random stall on the result side.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Result checking and the watchdog.
    always @(posedge clk)
    begin
        slab_hit_t want;
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                idle_cycles <= 0;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("ray_box_slab_test_top verification failed");
                $finish;
            end
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (pending_hits.size() == 0)
                begin
                    $error("result with nothing pending: hit %0b t_enter %0d t_leave %0d",
                           hit, t_enter, t_leave);
                    errors++;
                end
                else
                begin
                    want = pending_hits.pop_front();
                    if (hit)
                    begin
                        hits_seen++;
                    end
                    if (hit !== want.hit)
                    begin
                        $error("hit: expected %0b, got %0b", want.hit, hit);
                        errors++;
                    end
                    if (t_enter !== want.enter)
                    begin
                        $error("t_enter: expected %0d, got %0d", want.enter, t_enter);
                        errors++;
                    end
                    if (t_leave !== want.leave)
                    begin
                        $error("t_leave: expected %0d, got %0d", want.leave, t_leave);
                        errors++;
                    end
                end
            end
        end
    end

    // Stimulus: directed rows, then random requests across idling phases.
    initial
    begin
        int waited;
        rays_sent = 0;
        send_gap_pct = 0;
        stall_pct = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        req = '0;
        build_directed_rows();
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Typed rows are checked against their own outcome, the rest against the predictor.
        foreach (directed_rows[i])
        begin
            pending_hits.push_back(directed_rows[i].known ? directed_rows[i].outcome
                                                          : predict_slab_hit(directed_rows[i].rb));
            send_ray_box(directed_rows[i].rb);
        end

        for (int phase = 0; phase < 4; phase++)
        begin
            send_gap_pct = (phase == 1 || phase == 3) ? (phase == 1 ? 46 : 21) : 0;
            stall_pct = (phase == 2 || phase == 3) ? (phase == 2 ? 46 : 21) : 0;
            for (int n = 0; n < RANDOM_RAYS / 4; n++)
            begin
                ray_box_t rb;
                rb = random_ray_box();
                pending_hits.push_back(predict_slab_hit(rb));
                send_ray_box(rb);
            end
        end
        in_valid <= 1'b0;

        send_gap_pct = 0;
        stall_pct = 0;
        waited = 0;
        while (pending_hits.size() != 0 && waited < STALL_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d ray and box requests; %0d results checked, %0d of them hits.",
                 rays_sent, results_seen, hits_seen);
        if (errors == 0 && pending_hits.size() == 0)
        begin
            $display("ray_box_slab_test_top verification clean");
        end
        else
        begin
            $display("ray_box_slab_test_top verification failed");
        end
        $finish;
    end

endmodule
